FILE: hw/rtl/tssg_pkg.sv
`default_nettype none
package tssg_pkg;
  localparam int XW = 10;
  localparam int YW = 6;
  localparam int CW = 32;
  localparam logic [YW-1:0] ROW_MAX = 6'd62;
  localparam logic [XW-1:0] X_MAX = 10'd1023;

  // slope division selectors
  localparam logic [1:0] SEL_UP_ONE = 2'd0;
  localparam logic [1:0] SEL_UP_TWO = 2'd1;
  localparam logic [1:0] SEL_LO_ONE = 2'd2;
  localparam logic [1:0] SEL_LO_TWO = 2'd3;

  typedef struct packed {
    logic load;
    logic start_div;
    logic [1:0] div_sel;
    logic init_upper;
    logic init_lower;
    logic step_upper;
    logic step_lower;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic upper_end;
    logic lower_end;
  } sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/tssg_div.sv
`default_nettype none
module tssg_div #(
  parameter int NW = 40,
  parameter int DW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);
  localparam int CNTW = $clog2(NW + 1);
  logic [NW-1:0] q_q, q_d;
  logic [DW:0] r_q, r_d;
  logic [DW-1:0] den_q, den_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DW:0] sh;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh = '0;
    if (start_i) begin
      q_d = num_i;
      r_d = '0;
      den_d = den_i;
      cnt_d = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh = {r_q[DW-1:0], q_q[NW-1]};
      q_d = {q_q[NW-2:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        r_d = sh - {1'b0, den_q};
        q_d[0] = 1'b1;
      end else begin
        r_d = sh;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = q_q;
endmodule
`default_nettype wire

FILE: hw/rtl/tssg_datapath.sv
`default_nettype none
module tssg_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tssg_pkg::cmd_t         cmd_i,
  output tssg_pkg::sts_t              sts_o,
  input  wire logic [tssg_pkg::XW-1:0] ax_i,
  input  wire logic [tssg_pkg::YW-1:0] ay_i,
  input  wire logic [tssg_pkg::XW-1:0] bx_i,
  input  wire logic [tssg_pkg::YW-1:0] by_i,
  input  wire logic [tssg_pkg::XW-1:0] cx_i,
  input  wire logic [tssg_pkg::YW-1:0] cy_i,
  input  wire logic [tssg_pkg::CW-1:0] color_i,
  output logic [tssg_pkg::YW-1:0]     row_o,
  output logic [tssg_pkg::XW-1:0]     from_x_o,
  output logic [tssg_pkg::XW-1:0]     to_x_o,
  output logic [tssg_pkg::CW-1:0]     color_o
);
  localparam int XW = tssg_pkg::XW;
  localparam int YW = tssg_pkg::YW;
  localparam int AW = XW + FRAC_BITS + 2;
  localparam int NW = XW + YW + FRAC_BITS;

  logic [XW-1:0] x0_q, x1_q, x2_q, mx_q;
  logic [YW-1:0] y0_q, y1_q, y2_q, row_q;
  logic [tssg_pkg::CW-1:0] col_q;
  logic signed [AW-1:0] e1_q, e2_q, su1_q, su2_q, sl1_q, sl2_q;
  logic [YW-1:0] ya, yb, yc, t_y0, t_y1, t_y2;
  logic [XW-1:0] t_x0, t_x1, t_x2;
  logic [NW-1:0] num;
  logic [YW-1:0] den;
  logic neg;
  logic neg_q;
  logic [1:0] sel_q;
  logic div_done;
  logic [NW-1:0] quo;
  logic signed [AW-1:0] sq;
  logic [NW-1:0] mnum_q;
  logic mid_q;
  logic [YW-1:0] den_q;

  function automatic logic [YW-1:0] clamp_row(input logic [YW-1:0] y);
    clamp_row = (y > tssg_pkg::ROW_MAX) ? tssg_pkg::ROW_MAX : y;
  endfunction

  function automatic logic [XW-1:0] span_x(input logic signed [AW-1:0] acc);
    logic [AW-1:0] v;
    v = acc >>> FRAC_BITS;
    if (acc < 0) span_x = '0;
    else if (v > AW'(tssg_pkg::X_MAX)) span_x = tssg_pkg::X_MAX;
    else span_x = v[XW-1:0];
  endfunction

  always_comb begin
    logic [YW-1:0] ty;
    logic [XW-1:0] tx;
    ty = '0;
    tx = '0;
    ya = clamp_row(ay_i); yb = clamp_row(by_i); yc = clamp_row(cy_i);
    t_y0 = ya; t_x0 = ax_i; t_y1 = yb; t_x1 = bx_i; t_y2 = yc; t_x2 = cx_i;
    if (t_y0 > t_y1) begin
      ty = t_y0; t_y0 = t_y1; t_y1 = ty; tx = t_x0; t_x0 = t_x1; t_x1 = tx;
    end
    if (t_y0 > t_y2) begin
      ty = t_y0; t_y0 = t_y2; t_y2 = ty; tx = t_x0; t_x0 = t_x2; t_x2 = tx;
    end
    if (t_y1 > t_y2) begin
      ty = t_y1; t_y1 = t_y2; t_y2 = ty; tx = t_x1; t_x1 = t_x2; t_x2 = tx;
    end
  end

  // division operands: mid numerator, then four slopes
  always_comb begin
    logic [YW-1:0] h, d;
    logic signed [XW+1:0] dx;
    logic [XW:0] mag;
    h = y2_q - y0_q;
    d = y1_q - y0_q;
    dx = '0;
    den = '0;
    num = '0;
    neg = 1'b0;
    unique case (cmd_i.div_sel)
      tssg_pkg::SEL_UP_ONE: begin
        dx = $signed({2'b0, x1_q}) - $signed({2'b0, x0_q}); den = d;
      end
      tssg_pkg::SEL_UP_TWO: begin
        dx = $signed({2'b0, mx_q}) - $signed({2'b0, x0_q}); den = d;
      end
      tssg_pkg::SEL_LO_ONE: begin
        dx = $signed({2'b0, x2_q}) - $signed({2'b0, x1_q}); den = y2_q - y1_q;
      end
      default: begin
        dx = $signed({2'b0, x2_q}) - $signed({2'b0, mx_q}); den = y2_q - y1_q;
      end
    endcase
    neg = dx[XW+1];
    mag = neg ? (XW+1)'(-dx) : dx[XW:0];
    num = NW'(mag) << FRAC_BITS;
    if (mid_q) begin
      den = h;
      num = '0;
    end
  end

  // midpoint numerator x0*(h-d)+x2*d, registered at load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q <= '0; x1_q <= '0; x2_q <= '0; mx_q <= '0;
      y0_q <= '0; y1_q <= '0; y2_q <= '0; row_q <= '0;
      col_q <= '0;
      mnum_q <= '0;
      sel_q <= '0;
      neg_q <= 1'b0;
      den_q <= '0;
      e1_q <= '0; e2_q <= '0;
      su1_q <= '0; su2_q <= '0; sl1_q <= '0; sl2_q <= '0;
    end else begin
      if (cmd_i.load) begin
        x0_q <= t_x0; x1_q <= t_x1; x2_q <= t_x2;
        y0_q <= t_y0; y1_q <= t_y1; y2_q <= t_y2;
        col_q <= color_i;
        mnum_q <= NW'(t_x0) * NW'(t_y2 - t_y1) + NW'(t_x2) * NW'(t_y1 - t_y0);
        mx_q <= t_x0;
      end
      if (cmd_i.start_div) begin
        sel_q <= cmd_i.div_sel;
        neg_q <= neg;
        den_q <= den;
      end
      if (div_done && mid_q && (y2_q != y0_q)) mx_q <= quo[XW-1:0];
      if (cmd_i.init_upper) begin
        e1_q <= AW'({x0_q, FRAC_BITS'(0)});
        e2_q <= AW'({x0_q, FRAC_BITS'(0)});
        row_q <= y0_q;
      end else if (cmd_i.init_lower) begin
        e1_q <= AW'({x2_q, FRAC_BITS'(0)});
        e2_q <= AW'({x2_q, FRAC_BITS'(0)});
        row_q <= y2_q;
      end else if (cmd_i.step_upper) begin
        e1_q <= e1_q + su1_q; e2_q <= e2_q + su2_q; row_q <= row_q + 1'b1;
      end else if (cmd_i.step_lower) begin
        e1_q <= e1_q - sl1_q; e2_q <= e2_q - sl2_q; row_q <= row_q - 1'b1;
      end
      if (div_done && !mid_q) begin
        unique case (sel_q)
          tssg_pkg::SEL_UP_ONE: su1_q <= sq;
          tssg_pkg::SEL_UP_TWO: su2_q <= sq;
          tssg_pkg::SEL_LO_ONE: sl1_q <= sq;
          default: sl2_q <= sq;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mid_q <= 1'b0;
    else if (cmd_i.load) mid_q <= 1'b1;
    else if (div_done) mid_q <= 1'b0;
  end

  assign sq = (den_q == '0) ? '0 : (neg_q ? -AW'(quo) : AW'(quo));

  tssg_div #(.NW(NW), .DW(YW)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.start_div),
    .num_i(mid_q ? mnum_q : num),
    .den_i((den == '0) ? YW'(1) : den),
    .done_o(div_done),
    .quo_o(quo)
  );

  assign sts_o.div_done = div_done;
  assign sts_o.upper_end = (row_q == y1_q);
  assign sts_o.lower_end = (row_q == y1_q);
  assign row_o = row_q;
  assign from_x_o = span_x(e1_q);
  assign to_x_o = span_x(e2_q);
  assign color_o = col_q;
endmodule
`default_nettype wire

FILE: hw/rtl/tssg_ctrl.sv
`default_nettype none
module tssg_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic                out_last_o,
  output tssg_pkg::cmd_t      cmd_o,
  input  wire tssg_pkg::sts_t sts_i
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVS = 3'd1;
  localparam logic [2:0] S_DIVW = 3'd2;
  localparam logic [2:0] S_UPPER = 3'd3;
  localparam logic [2:0] S_LOWER = 3'd4;

  logic [2:0] st_q, st_d;
  logic [2:0] k_q, k_d;
  logic fire;

  assign fire = out_valid_o && out_ready_i;

  always_comb begin
    st_d = st_q;
    k_d = k_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    out_last_o = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = S_DIVS;
          k_d = 3'd0;
        end
      end
      S_DIVS: begin
        // k 0: midpoint, 1..4: slopes
        cmd_o.start_div = 1'b1;
        cmd_o.div_sel = 2'(k_q - 3'd1);
        st_d = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          k_d = k_q + 3'd1;
          if (k_q == 3'd4) begin
            cmd_o.init_upper = 1'b1;
            st_d = S_UPPER;
          end else begin
            st_d = S_DIVS;
          end
        end
      end
      S_UPPER: begin
        out_valid_o = 1'b1;
        if (fire) begin
          if (sts_i.upper_end) begin
            cmd_o.init_lower = 1'b1;
            st_d = S_LOWER;
          end else begin
            cmd_o.step_upper = 1'b1;
          end
        end
      end
      S_LOWER: begin
        out_valid_o = 1'b1;
        out_last_o = sts_i.lower_end;
        if (fire) begin
          if (sts_i.lower_end) st_d = S_IDLE;
          else cmd_o.step_lower = 1'b1;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      k_q <= '0;
    end else begin
      st_q <= st_d;
      k_q <= k_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while emitting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> st_q == S_DIVS) else $error("no setup");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && out_last_o) |=> st_q == S_IDLE) else $error("no idle after last");
endmodule
`default_nettype wire

FILE: hw/rtl/triangle_scanline_span_generator.sv
`default_nettype none
// triangle in on the s_axis channel, spans out on m_axis, one request each.
// a triangle is taken only while idle. setup sorts the vertices, then runs
// five divisions (midpoint and four slopes) on one shared restoring divider
// of XW+YW+FRAC_BITS steps each. spans then leave at one per cycle while
// m_axis_tready is high: rows top to middle, then bottom to middle,
// (y2-y0)+2 spans, tlast on the final. a stalled receiver holds the
// current span; the edge walk waits with it. the next triangle is taken
// only after the final span of this one has left.
// reset (rst_ni low, asynchronous) returns the controller to idle and drops
// any triangle in progress.
// s_axis_tdata: vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x,
// vert_c_y, fill_color from bit 0 up.
// m_axis_tdata: span_row, span_from_x, span_to_x, span_color from bit 0 up.
// m_axis_tlast: span_last.
module triangle_scanline_span_generator #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // a_x, a_y, b_x, b_y, c_x, c_y, colour
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // row, from_x, to_x, colour, zero pad
  output logic             m_axis_tlast   // span_last
);
  tssg_pkg::cmd_t cmd;
  tssg_pkg::sts_t sts;
  logic [5:0] row;
  logic [9:0] fx, tx;
  logic [31:0] col;

  tssg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_last_o(m_axis_tlast),
    .cmd_o(cmd), .sts_i(sts)
  );

  tssg_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .ax_i(s_axis_tdata[9:0]), .ay_i(s_axis_tdata[15:10]),
    .bx_i(s_axis_tdata[25:16]), .by_i(s_axis_tdata[31:26]),
    .cx_i(s_axis_tdata[41:32]), .cy_i(s_axis_tdata[47:42]),
    .color_i(s_axis_tdata[79:48]),
    .row_o(row), .from_x_o(fx), .to_x_o(tx), .color_o(col)
  );

  assign m_axis_tdata = {6'b0, col, tx, fx, row};
endmodule
`default_nettype wire

FILE: tb/testbench.sv
module testbench;
  localparam int FRAC = 16;
  localparam int LIMIT = 20000;
  localparam int N_RANDOM = 440;

  typedef struct packed {
    logic [5:0] row;
    logic [9:0] from_x;
    logic [9:0] to_x;
    logic [31:0] color;
    logic last;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tlast;

  int errors = 0;
  int stall_pct = 26;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  triangle_scanline_span_generator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  class span_board;
    span_t pending[$];

    function longint edge_slope(longint dx, longint dy);
      longint q;
      if (dy <= 0) return 0;
      q = ((dx < 0 ? -dx : dx) <<< FRAC) / dy;
      return dx < 0 ? -q : q;
    endfunction

    function logic [9:0] to_pixel(longint acc);
      longint v;
      if (acc < 0) return '0;
      v = acc >>> FRAC;
      return v > 1023 ? 10'd1023 : v[9:0];
    endfunction

    function void note_triangle(logic [79:0] d);
      longint vx[3], vy[3], t, h, dm, mx, ex1, ex2, s1, s2;
      span_t s;
      for (int i = 0; i < 3; i++) begin
        vx[i] = d[16*i +: 10];
        vy[i] = d[16*i+10 +: 6];
        if (vy[i] > tssg_pkg::ROW_MAX) vy[i] = tssg_pkg::ROW_MAX;
      end
      for (int p = 0; p < 3; p++) begin
        int a, b;
        a = (p == 2) ? 1 : 0;
        b = (p == 0) ? 1 : 2;
        if (vy[a] > vy[b]) begin
          t = vy[a]; vy[a] = vy[b]; vy[b] = t;
          t = vx[a]; vx[a] = vx[b]; vx[b] = t;
        end
      end
      h = vy[2] - vy[0];
      dm = vy[1] - vy[0];
      mx = (h == 0) ? vx[0] : (vx[0] * (h - dm) + vx[2] * dm) / h;
      s.color = d[79:48];
      s.last = 1'b0;
      ex1 = vx[0] <<< FRAC; ex2 = ex1;
      s1 = edge_slope(vx[1] - vx[0], dm);
      s2 = edge_slope(mx - vx[0], dm);
      for (longint y = vy[0]; y <= vy[1]; y++) begin
        s.row = y[5:0]; s.from_x = to_pixel(ex1); s.to_x = to_pixel(ex2);
        pending.push_back(s);
        ex1 += s1; ex2 += s2;
      end
      ex1 = vx[2] <<< FRAC; ex2 = ex1;
      s1 = edge_slope(vx[2] - vx[1], vy[2] - vy[1]);
      s2 = edge_slope(vx[2] - mx, vy[2] - vy[1]);
      for (longint y = vy[2]; y >= vy[1]; y--) begin
        s.row = y[5:0]; s.from_x = to_pixel(ex1); s.to_x = to_pixel(ex2);
        s.last = (y == vy[1]);
        pending.push_back(s);
        ex1 -= s1; ex2 -= s2;
      end
    endfunction

    function int check_span(logic [63:0] d, logic last);
      span_t e;
      int bad = 0;
      if (pending.size() == 0) begin
        $error("unexpected span %h", d);
        return 1;
      end
      e = pending.pop_front();
      if (d[5:0] !== e.row) begin
        $error("span_row exp %0d got %0d", e.row, d[5:0]); bad++;
      end
      if (d[15:6] !== e.from_x) begin
        $error("span_from_x exp %0d got %0d", e.from_x, d[15:6]); bad++;
      end
      if (d[25:16] !== e.to_x) begin
        $error("span_to_x exp %0d got %0d", e.to_x, d[25:16]); bad++;
      end
      if (d[57:26] !== e.color) begin
        $error("span_color exp %h got %h", e.color, d[57:26]); bad++;
      end
      if (last !== e.last) begin
        $error("span_last exp %0d got %0d", e.last, last); bad++;
      end
      return bad;
    endfunction
  endclass

  span_board board = new();

  function logic [79:0] pack_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                 logic [31:0] col);
    return {col, 6'(cy), 10'(cx), 6'(by), 10'(bx), 6'(ay), 10'(ax)};
  endfunction

  task automatic send_triangle(logic [79:0] d);
    while (stall_pct > 0 && $urandom_range(99) < stall_pct) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_triangle(d);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  function int rand_y();
    case ($urandom_range(9))
      0: return 0;
      1: return 63;
      2: return 62;
      3: return $urandom_range(63);
      default: return $urandom_range(15);
    endcase
  endfunction

  function int rand_x();
    case ($urandom_range(5))
      0: return 0;
      1: return 1023;
      default: return $urandom_range(1023);
    endcase
  endfunction

  // receiver
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      errors += board.check_span(m_axis_tdata, m_axis_tlast);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else if (rst_ni && !hold_off) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_triangle(pack_tri(0, 0, 1023, 62, 0, 62, 32'hFFFF_FFFF));
    send_triangle(pack_tri(1023, 62, 0, 0, 1023, 0, 32'h0000_0000));
    send_triangle(pack_tri(5, 10, 900, 10, 300, 10, 32'hA5A5_A5A5));
    send_triangle(pack_tri(100, 63, 200, 63, 300, 63, 32'h5A5A_5A5A));
    send_triangle(pack_tri(512, 0, 0, 63, 1023, 30, 32'h1234_5678));
    send_triangle(pack_tri(0, 30, 1023, 0, 0, 63, 32'h8765_4321));
    send_triangle(pack_tri(1023, 5, 1023, 20, 0, 20, 32'hDEAD_BEEF));
    send_triangle(pack_tri(0, 20, 1023, 5, 1023, 5, 32'hCAFE_F00D));
    send_triangle(pack_tri(1, 1, 2, 2, 3, 3, 32'h0000_0001));
    send_triangle(pack_tri(1022, 62, 1, 0, 511, 1, 32'h8000_0000));
    send_triangle(pack_tri(341, 21, 682, 42, 1023, 63, 32'h7FFF_FFFF));
    send_triangle(pack_tri(700, 40, 10, 3, 990, 3, 32'h0F0F_0F0F));

    // pause until the scoreboard drains
    wait (board.pending.size() == 0);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 4; i++)
        send_triangle(pack_tri(rand_x(), rand_y(), rand_x(), rand_y(), rand_x(), rand_y(),
                               $urandom()));
    join

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 150) stall_pct = 0;
      if (i == 250) stall_pct = 26;
      send_triangle(pack_tri(rand_x(), rand_y(), rand_x(), rand_y(), rand_x(), rand_y(),
                             $urandom()));
    end

    wait (board.pending.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
